/* hdl/assert_macros.svh */
// assertion macros used by ips_patch_stream_decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true outside of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hdl/ipsd_pkg.sv */
// types, codes and constants of the patch stream decoder
`timescale 1ns / 1ps
`default_nettype none

package ipsd_pkg;

  localparam int unsigned ADDR_W = 25;
  localparam int unsigned OFF_W  = 24;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned CNT_W  = 3;

  localparam logic [OFF_W-1:0] EOF_MARK     = 24'h454F46;
  localparam logic [LEN_W-1:0] NO_TRUNC     = 32'hFFFFFFFF;
  localparam logic [CNT_W-1:0] MAGIC_LEN    = 3'd5;
  localparam logic [CNT_W-1:0] OFF_BYTES    = 3'd3;
  localparam logic [CNT_W-1:0] SIZE_BYTES   = 3'd2;
  localparam logic [CNT_W-1:0] TRAIL_BYTES  = 3'd3;
  localparam logic [LEN_W-1:0] SOURCE_RESET = 32'd0;

  // result kinds
  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // summary status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SCRAMBLED = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NOT_THIS  = 2'd3
  } status_t;

  // parser phases
  typedef enum logic [7:0] {
    PH_HDR    = 8'b0000_0001,
    PH_OFF    = 8'b0000_0010,
    PH_SIZE   = 8'b0000_0100,
    PH_RUNLEN = 8'b0000_1000,
    PH_FILL   = 8'b0001_0000,
    PH_LIT    = 8'b0010_0000,
    PH_TRAIL  = 8'b0100_0000,
    PH_SINK   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] patch_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
    logic [SIZE_W-1:0] run_length;
    status_t           status;
    logic [LEN_W-1:0]  out_length;
    logic [ADDR_W-1:0] highest_end;
    logic              has_truncation;
    logic [OFF_W-1:0]  truncation_length;
  } out_item_t;

  // header bytes "PATCH"
  function automatic logic [7:0] magic_byte(input logic [CNT_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h50;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hdl/ips_patch_stream_decoder.sv */
// patch stream decoder: ips patch bytes in, write, fill and summary requests out
//
// Input channel in_valid/in_ready/in_item carries one patch byte and a last mark.
// Output channel out_valid/out_ready/out_item carries a byte write, a fill run
// or, on the last byte, the final summary; commands are speculative and must be
// dropped by the user when the summary status is invalid.
// cfg_write/cfg_data set the source length; write it only while idle.
// Path: a byte is held in the input register, then passes through the parser logic
// into the result register.
// Throughput: one byte per cycle while the receiver takes results, limited by the single parser state update.
// A byte that gives no result still passes through the parser and updates its state.
// When the receiver stalls, the result register holds its request and the
// parser stops; the input register takes a byte only while empty, then in_ready drops.
// Reset (rst, synchronous) empties both registers, returns the parser to the
// header phase and sets the source length to SOURCE_LENGTH_RESET (zero by default).
// After each last byte the parser returns to the header phase on its own; the source length is kept.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ips_patch_stream_decoder #(
  parameter logic [ipsd_pkg::LEN_W-1:0] SOURCE_LENGTH_RESET = ipsd_pkg::SOURCE_RESET
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ipsd_pkg::in_item_t          in_item,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ipsd_pkg::out_item_t              out_item,
  input  wire logic                        cfg_write,
  input  wire logic [ipsd_pkg::LEN_W-1:0]  cfg_data
);

  logic [ipsd_pkg::LEN_W-1:0] source_length;
  logic                       advance;
  logic                       q_valid;
  ipsd_pkg::in_item_t         q_item;
  logic                       res_valid;
  ipsd_pkg::out_item_t        res_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      source_length <= SOURCE_LENGTH_RESET;
    end else if (cfg_write) begin
      source_length <= cfg_data;
    end
  end

  // held byte moves through the parser when the result register has room
  assign advance = q_valid && (!out_valid || out_ready);

  ipsd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  ipsd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (q_item),
    .source_length (source_length),
    .res_valid     (res_valid),
    .res_item      (res_item)
  );

  ipsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // checks
  `ASSERT_NEVER(a_no_overwrite, out_valid && !out_ready && advance, "result overwritten while stalled")
  `ASSERT_CLK(a_last_summary, advance && q_item.is_last |=> out_valid && out_item.kind == ipsd_pkg::KIND_SUMMARY, "last byte gave no summary")
  `ASSERT_CLK(a_invalid_zero, out_valid && out_item.kind == ipsd_pkg::KIND_SUMMARY && out_item.status == ipsd_pkg::ST_INVALID |-> out_item.out_length == '0 && out_item.highest_end == '0 && !out_item.has_truncation, "invalid summary carries lengths")
  `ASSERT_CLK(a_cmd_clean, out_valid && out_item.kind != ipsd_pkg::KIND_SUMMARY |-> out_item.status == ipsd_pkg::ST_OK && out_item.out_length == '0, "command carries summary fields")

endmodule

`default_nettype wire

/* hdl/ipsd_in_reg.sv */
// input register that holds one patch byte request
`timescale 1ns / 1ps
`default_nettype none

module ipsd_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ipsd_pkg::in_item_t in_item,
  input  wire logic              take,
  output logic                   q_valid,
  output ipsd_pkg::in_item_t     q_item
);

  // room when empty or when the held request moves on this cycle
  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* hdl/ipsd_parser.sv */
// parser state and per-byte command and summary logic
`timescale 1ns / 1ps
`default_nettype none

module ipsd_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire ipsd_pkg::in_item_t             item,
  input  wire logic [ipsd_pkg::LEN_W-1:0]     source_length,
  output logic                                res_valid,
  output ipsd_pkg::out_item_t                 res_item
);

  ipsd_pkg::phase_t              phase, phase_next;
  logic [ipsd_pkg::CNT_W-1:0]    field_byte_count, field_byte_count_next;
  logic [ipsd_pkg::OFF_W-1:0]    record_offset, record_offset_next;
  logic [ipsd_pkg::SIZE_W-1:0]   record_size, record_size_next;
  logic [ipsd_pkg::SIZE_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [ipsd_pkg::ADDR_W-1:0]   max_end, max_end_next;
  logic [ipsd_pkg::OFF_W-1:0]    trailer_value, trailer_value_next;
  logic                          failed, failed_next;

  logic [7:0]                    b;
  logic [ipsd_pkg::CNT_W-1:0]    cnt_inc;
  logic [ipsd_pkg::SIZE_W-1:0]   size_shift;
  logic [ipsd_pkg::OFF_W-1:0]    off_shift;
  logic [ipsd_pkg::ADDR_W-1:0]   rec_end;
  logic [ipsd_pkg::SIZE_W-1:0]   lit_pos;
  logic                          valid_end;
  logic                          has_t;
  logic [ipsd_pkg::LEN_W-1:0]    tv_ext;
  logic [ipsd_pkg::LEN_W-1:0]    end_ext;
  logic [ipsd_pkg::LEN_W-1:0]    min_len;
  logic [ipsd_pkg::LEN_W-1:0]    lim;

  assign b          = item.patch_byte;
  assign cnt_inc    = field_byte_count + 3'd1;
  assign off_shift  = {record_offset[ipsd_pkg::OFF_W-9:0], b};
  assign size_shift = {record_size[ipsd_pkg::SIZE_W-9:0], b};
  assign rec_end    = {1'b0, record_offset} + {9'd0, size_shift};
  assign lit_pos    = record_size - bytes_remaining;

  // next state and command for one byte
  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    record_offset_next    = record_offset;
    record_size_next      = record_size;
    bytes_remaining_next  = bytes_remaining;
    max_end_next          = max_end;
    trailer_value_next    = trailer_value;
    failed_next           = failed;
    res_valid             = 1'b0;
    res_item              = '0;

    unique case (phase)
      ipsd_pkg::PH_HDR: begin
        if (field_byte_count >= ipsd_pkg::MAGIC_LEN ||
            b != ipsd_pkg::magic_byte(field_byte_count)) begin
          failed_next = 1'b1;
          phase_next  = ipsd_pkg::PH_SINK;
        end else if (cnt_inc == ipsd_pkg::MAGIC_LEN) begin
          field_byte_count_next = '0;
          phase_next            = ipsd_pkg::PH_OFF;
        end else begin
          field_byte_count_next = cnt_inc;
        end
      end
      ipsd_pkg::PH_OFF: begin
        record_offset_next    = off_shift;
        field_byte_count_next = cnt_inc;
        if (cnt_inc >= ipsd_pkg::OFF_BYTES) begin
          field_byte_count_next = '0;
          if (off_shift == ipsd_pkg::EOF_MARK) begin
            phase_next         = ipsd_pkg::PH_TRAIL;
            trailer_value_next = '0;
          end else begin
            phase_next = ipsd_pkg::PH_SIZE;
          end
        end
      end
      ipsd_pkg::PH_SIZE, ipsd_pkg::PH_RUNLEN: begin
        record_size_next      = size_shift;
        field_byte_count_next = cnt_inc;
        if (cnt_inc >= ipsd_pkg::SIZE_BYTES) begin
          field_byte_count_next = '0;
          if (phase == ipsd_pkg::PH_SIZE) begin
            if (size_shift != '0) begin
              bytes_remaining_next = size_shift;
              if (rec_end > max_end) max_end_next = rec_end;
              phase_next = ipsd_pkg::PH_LIT;
            end else begin
              phase_next = ipsd_pkg::PH_RUNLEN;
            end
          end else if (size_shift == '0) begin
            // zero run length
            failed_next = 1'b1;
            phase_next  = ipsd_pkg::PH_SINK;
          end else begin
            if (rec_end > max_end) max_end_next = rec_end;
            phase_next = ipsd_pkg::PH_FILL;
          end
        end
      end
      ipsd_pkg::PH_FILL: begin
        res_valid           = 1'b1;
        res_item.kind       = ipsd_pkg::KIND_FILL;
        res_item.address    = {1'b0, record_offset};
        res_item.data       = b;
        res_item.run_length = record_size;
        phase_next          = ipsd_pkg::PH_OFF;
      end
      ipsd_pkg::PH_LIT: begin
        res_valid        = 1'b1;
        res_item.kind    = ipsd_pkg::KIND_WRITE;
        res_item.address = {1'b0, record_offset} + {9'd0, lit_pos};
        res_item.data    = b;
        if (bytes_remaining != '0) bytes_remaining_next = bytes_remaining - 16'd1;
        if (bytes_remaining <= 16'd1) phase_next = ipsd_pkg::PH_OFF;
      end
      ipsd_pkg::PH_TRAIL: begin
        if (field_byte_count >= ipsd_pkg::TRAIL_BYTES) begin
          // fourth trailer byte
          failed_next = 1'b1;
          phase_next  = ipsd_pkg::PH_SINK;
        end else begin
          trailer_value_next    = {trailer_value[ipsd_pkg::OFF_W-9:0], b};
          field_byte_count_next = cnt_inc;
        end
      end
      ipsd_pkg::PH_SINK: begin
      end
      default: begin
      end
    endcase

    // summary on the last byte, judged on the updated state
    valid_end = !failed_next && phase_next == ipsd_pkg::PH_TRAIL &&
                (field_byte_count_next == '0 ||
                 field_byte_count_next == ipsd_pkg::TRAIL_BYTES);
    has_t   = field_byte_count_next == ipsd_pkg::TRAIL_BYTES;
    tv_ext  = {8'd0, trailer_value_next};
    end_ext = {7'd0, max_end_next};
    min_len = end_ext;
    if (has_t && end_ext > tv_ext) min_len = tv_ext;
    lim = source_length;
    if (has_t && tv_ext < source_length) lim = tv_ext;

    if (item.is_last) begin
      res_valid     = 1'b1;
      res_item      = '0;
      res_item.kind = ipsd_pkg::KIND_SUMMARY;
      if (!valid_end) begin
        res_item.status = ipsd_pkg::ST_INVALID;
      end else begin
        res_item.status = ipsd_pkg::ST_OK;
        if (has_t && end_ext > tv_ext) res_item.status = ipsd_pkg::ST_SCRAMBLED;
        if (has_t && source_length <= tv_ext) res_item.status = ipsd_pkg::ST_NOT_THIS;
        res_item.out_length        = (lim > min_len) ? lim : min_len;
        res_item.highest_end       = max_end_next;
        res_item.has_truncation    = has_t;
        res_item.truncation_length = has_t ? trailer_value_next : '0;
      end
    end
  end

  // state registers, cleared again after every last byte
  always_ff @(posedge clk) begin
    if (rst || (step && item.is_last)) begin
      phase            <= ipsd_pkg::PH_HDR;
      field_byte_count <= '0;
      record_offset    <= '0;
      record_size      <= '0;
      bytes_remaining  <= '0;
      max_end          <= '0;
      trailer_value    <= '0;
      failed           <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      record_offset    <= record_offset_next;
      record_size      <= record_size_next;
      bytes_remaining  <= bytes_remaining_next;
      max_end          <= max_end_next;
      trailer_value    <= trailer_value_next;
      failed           <= failed_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/ipsd_out_reg.sv */
// result register toward the receiver
`timescale 1ns / 1ps
`default_nettype none

module ipsd_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire logic                res_valid,
  input  wire ipsd_pkg::out_item_t res_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ipsd_pkg::out_item_t      out_item
);

  // load only happens when empty or when the held request leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      out_item <= res_item;
    end
  end

endmodule

`default_nettype wire
